// ===== rtl/tsi_pkg.sv =====
`timescale 1ns / 1ps
package tsi_pkg;

    localparam int SLOTS         = 3;
    localparam int PERIOD_W      = 10;
    localparam int RELOAD_W      = 17;
    localparam int CLOCK_W       = 24;
    localparam int TOKEN_W       = 8;
    localparam int ATT_W         = 4;
    localparam int FREQ_W        = 16;
    localparam int NUM_W         = 47;
    localparam int DEN_W         = 41;
    localparam int REM_W         = 58;
    localparam int INDEX_W       = 5;
    localparam int IMG_MAX       = 32;
    localparam int FRAC_SHIFT    = 24;
    localparam int PSG_DIV_SHIFT = 5;
    localparam int QUOT_BITS     = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CLOCK_W-1:0] SID_CLOCK_RESET = 24'd985248;

    localparam int RETRIG_INDEX = 0;
    localparam int VOICE_BASE   = 1;
    localparam int VOICE_STRIDE = 7;
    localparam int OFS_FREQ_LO  = 0;
    localparam int OFS_FREQ_HI  = 1;
    localparam int OFS_PW_HI    = 3;
    localparam int OFS_CTRL     = 4;
    localparam int OFS_SR       = 6;
    localparam int VOLUME_INDEX = 25;

    localparam logic [7:0] PULSE_WIDTH_HI = 8'h08;
    localparam logic [7:0] CTRL_PULSE_GATE = 8'h41;
    localparam logic [7:0] MASTER_VOLUME = 8'h0f;

    typedef logic [RELOAD_W-1:0] opnd_t;
    typedef logic [CLOCK_W-1:0]  clock_t;
    typedef logic [NUM_W-1:0]    num_t;
    typedef logic [DEN_W-1:0]    den_t;
    typedef logic [REM_W-1:0]    rem_t;
    typedef logic [FREQ_W-1:0]   freq_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [1:0]          slot_t;
    typedef logic [3:0]          bitcnt_t;
    typedef logic [0:0]          qptr_t;
    typedef logic [1:0]          qcnt_t;
    typedef logic [IMG_MAX-1:0][7:0] image_t;

    typedef struct packed {
        logic                             psg;
        logic [SLOTS-1:0]                 active;
        opnd_t [SLOTS-1:0]                opnd;
        logic [SLOTS-1:0][ATT_W-1:0]      att;
        logic [SLOTS-1:0][TOKEN_W-1:0]    tok;
        logic [TOKEN_W-1:0]               spk_tok;
    } job_t;

endpackage

// ===== rtl/tsi_front.sv =====
`timescale 1ns / 1ps
module tsi_front
(
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 speaker_active,
    input  logic [16:0]          speaker_reload,
    input  logic [7:0]           speaker_token,
    input  logic                 tandy_enabled,
    input  logic [2:0]           voice_active_mask,
    input  logic [29:0]          voice_periods,
    input  logic [11:0]          voice_attenuations,
    input  logic [23:0]          voice_tokens,
    input  tsi_pkg::clock_t      sid_clock,
    input  logic                 q_full,
    output logic                 push,
    output tsi_pkg::job_t        job
);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        logic [tsi_pkg::PERIOD_W-1:0] per;
        logic                         psg;
        job = '0;
        per = '0;
        psg = tandy_enabled && (sid_clock != '0);
        job.psg     = psg;
        job.spk_tok = speaker_token;
        if (psg)
        begin
            for (int v = 0; v < tsi_pkg::SLOTS; v++)
            begin
                per = voice_periods[v*tsi_pkg::PERIOD_W +: tsi_pkg::PERIOD_W];
                job.active[v] = voice_active_mask[v] && (per != '0);
                job.opnd[v]   = tsi_pkg::opnd_t'(per) << tsi_pkg::PSG_DIV_SHIFT;
                job.att[v]    = voice_attenuations[v*tsi_pkg::ATT_W +: tsi_pkg::ATT_W];
                job.tok[v]    = voice_tokens[v*tsi_pkg::TOKEN_W +: tsi_pkg::TOKEN_W];
            end
        end
        else
        begin
            // speaker rides in slot 0; zero attenuation gives sustain 0xf0
            job.active[0] = speaker_active && (speaker_reload != '0) && (sid_clock != '0);
            job.opnd[0]   = speaker_reload;
            job.tok[0]    = speaker_token;
        end
    end

endmodule

// ===== rtl/tsi_queue.sv =====
`timescale 1ns / 1ps
module tsi_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsi_pkg::job_t  job_in,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output tsi_pkg::job_t  job_out
);

    tsi_pkg::job_t  mem_reg [tsi_pkg::QUEUE_DEPTH];
    tsi_pkg::qptr_t wr_ptr_reg, wr_ptr_next;
    tsi_pkg::qptr_t rd_ptr_reg, rd_ptr_next;
    tsi_pkg::qcnt_t count_reg, count_next;

    assign full    = count_reg == tsi_pkg::qcnt_t'(tsi_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign job_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + tsi_pkg::qptr_t'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + tsi_pkg::qptr_t'(1);
        if (push && !pop)
            count_next = count_reg + tsi_pkg::qcnt_t'(1);
        else if (pop && !push)
            count_next = count_reg - tsi_pkg::qcnt_t'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= job_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/tsi_engine.sv =====
`timescale 1ns / 1ps
module tsi_engine
#(
    parameter int PIT_CLOCK_HZ = 1193182,
    parameter int PSG_CLOCK_HZ = 3579545
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tsi_pkg::clock_t  sid_clock,
    input  logic             q_valid,
    input  tsi_pkg::job_t    job_in,
    output logic             pop,
    output logic             img_valid,
    input  logic             img_ready,
    output tsi_pkg::image_t  img
);

    localparam tsi_pkg::num_t PIT_NUM = tsi_pkg::num_t'(PIT_CLOCK_HZ) << tsi_pkg::FRAC_SHIFT;
    localparam tsi_pkg::num_t PSG_NUM = tsi_pkg::num_t'(PSG_CLOCK_HZ) << tsi_pkg::FRAC_SHIFT;

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_CHK  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } eng_state_t;

    eng_state_t        state_reg, state_next;
    tsi_pkg::job_t     job_reg, job_next;
    tsi_pkg::slot_t    slot_reg, slot_next;
    tsi_pkg::den_t     den_reg, den_next;
    tsi_pkg::num_t     rem_reg, rem_next;
    tsi_pkg::rem_t     dsh_reg, dsh_next;
    tsi_pkg::freq_t    quo_reg, quo_next;
    tsi_pkg::bitcnt_t  bit_reg, bit_next;
    tsi_pkg::freq_t    freq_reg [tsi_pkg::SLOTS];
    tsi_pkg::freq_t    freq_next [tsi_pkg::SLOTS];

    logic [tsi_pkg::TOKEN_W-1:0] prev_spk_tok_reg, prev_spk_tok_next;
    logic                        spk_sounding_reg, spk_sounding_next;
    logic [tsi_pkg::TOKEN_W-1:0] prev_voice_tok_reg [tsi_pkg::SLOTS];
    logic [tsi_pkg::TOKEN_W-1:0] prev_voice_tok_next [tsi_pkg::SLOTS];
    logic [tsi_pkg::SLOTS-1:0]   voice_sounding_reg, voice_sounding_next;

    logic [tsi_pkg::SLOTS-1:0]   freq_nz;
    tsi_pkg::den_t               den_prod;
    tsi_pkg::num_t               numer;
    tsi_pkg::num_t               sum;
    logic                        sat;
    logic                        fits;
    tsi_pkg::num_t               diff;
    tsi_pkg::freq_t              quo_step;
    logic                        last_slot;
    logic                        rec;
    tsi_pkg::freq_t              rec_val;

    assign den_prod  = tsi_pkg::den_t'(job_reg.opnd[slot_reg]) * tsi_pkg::den_t'(sid_clock);
    assign numer     = job_reg.psg ? PSG_NUM : PIT_NUM;
    // rounding: add half the divisor before dividing
    assign sum       = numer + tsi_pkg::num_t'(den_reg >> 1);
    assign sat       = tsi_pkg::rem_t'(sum) >= (tsi_pkg::rem_t'(den_reg) << tsi_pkg::QUOT_BITS);
    assign fits      = tsi_pkg::rem_t'(rem_reg) >= dsh_reg;
    assign diff      = tsi_pkg::num_t'(tsi_pkg::rem_t'(rem_reg) - dsh_reg);
    assign quo_step  = tsi_pkg::freq_t'({quo_reg, fits});
    assign last_slot = slot_reg == tsi_pkg::slot_t'(tsi_pkg::SLOTS - 1);

    always_comb
    begin
        state_next          = state_reg;
        job_next            = job_reg;
        slot_next           = slot_reg;
        den_next            = den_reg;
        rem_next            = rem_reg;
        dsh_next            = dsh_reg;
        quo_next            = quo_reg;
        bit_next            = bit_reg;
        freq_next           = freq_reg;
        prev_spk_tok_next   = prev_spk_tok_reg;
        spk_sounding_next   = spk_sounding_reg;
        prev_voice_tok_next = prev_voice_tok_reg;
        voice_sounding_next = voice_sounding_reg;
        pop                 = 1'b0;
        img_valid           = 1'b0;
        rec                 = 1'b0;
        rec_val             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                pop = q_valid;
                if (q_valid)
                begin
                    job_next   = job_in;
                    slot_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (job_reg.active[slot_reg])
                begin
                    den_next   = den_prod;
                    state_next = ST_CHK;
                end
                else
                begin
                    rec = 1'b1;
                end
            end
            ST_CHK:
            begin
                rem_next = sum;
                dsh_next = tsi_pkg::rem_t'(den_reg) << (tsi_pkg::QUOT_BITS - 1);
                quo_next = '0;
                bit_next = tsi_pkg::bitcnt_t'(tsi_pkg::QUOT_BITS - 1);
                if (sat)
                begin
                    rec     = 1'b1;
                    rec_val = '1;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (fits)
                    rem_next = diff;
                dsh_next = dsh_reg >> 1;
                quo_next = quo_step;
                bit_next = bit_reg - tsi_pkg::bitcnt_t'(1);
                if (bit_reg == '0)
                begin
                    rec     = 1'b1;
                    rec_val = quo_step;
                end
            end
            ST_FIN:
            begin
                img_valid = 1'b1;
                if (img_ready)
                begin
                    state_next        = ST_IDLE;
                    prev_spk_tok_next = job_reg.spk_tok;
                    if (job_reg.psg)
                    begin
                        spk_sounding_next = 1'b0;
                        for (int v = 0; v < tsi_pkg::SLOTS; v++)
                        begin
                            voice_sounding_next[v] = freq_nz[v];
                            if (freq_nz[v])
                                prev_voice_tok_next[v] = job_reg.tok[v];
                        end
                    end
                    else
                    begin
                        spk_sounding_next   = freq_nz[0];
                        voice_sounding_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rec)
        begin
            freq_next[slot_reg] = rec_val;
            if (last_slot)
            begin
                state_next = ST_FIN;
            end
            else
            begin
                slot_next  = slot_reg + tsi_pkg::slot_t'(1);
                state_next = ST_MUL;
            end
        end
    end

    always_comb
    begin
        int  base;
        logic retrig;
        img    = '0;
        base   = 0;
        retrig = 1'b0;
        for (int v = 0; v < tsi_pkg::SLOTS; v++)
        begin
            base       = tsi_pkg::VOICE_BASE + tsi_pkg::VOICE_STRIDE * v;
            freq_nz[v] = freq_reg[v] != '0;
            if (job_reg.psg)
                retrig = !voice_sounding_reg[v] || (prev_voice_tok_reg[v] != job_reg.tok[v]);
            else
                retrig = !spk_sounding_reg || (prev_spk_tok_reg != job_reg.spk_tok);
            if (freq_nz[v])
            begin
                img[tsi_pkg::RETRIG_INDEX][v]       = retrig;
                img[base + tsi_pkg::OFS_FREQ_LO]    = freq_reg[v][7:0];
                img[base + tsi_pkg::OFS_FREQ_HI]    = freq_reg[v][15:8];
                img[base + tsi_pkg::OFS_PW_HI]      = tsi_pkg::PULSE_WIDTH_HI;
                img[base + tsi_pkg::OFS_CTRL]       = tsi_pkg::CTRL_PULSE_GATE;
                img[base + tsi_pkg::OFS_SR]         = {~job_reg.att[v], 4'b0000};
            end
        end
        if (job_reg.psg || freq_nz[0])
            img[tsi_pkg::VOLUME_INDEX] = tsi_pkg::MASTER_VOLUME;
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
        freq_reg <= freq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            slot_reg           <= '0;
            prev_spk_tok_reg   <= '0;
            spk_sounding_reg   <= 1'b0;
            prev_voice_tok_reg <= '{default: '0};
            voice_sounding_reg <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            slot_reg           <= slot_next;
            prev_spk_tok_reg   <= prev_spk_tok_next;
            spk_sounding_reg   <= spk_sounding_next;
            prev_voice_tok_reg <= prev_voice_tok_next;
            voice_sounding_reg <= voice_sounding_next;
        end
    end

endmodule

// ===== rtl/tsi_emit.sv =====
`timescale 1ns / 1ps
module tsi_emit
#(
    parameter int IMAGE_BYTES = 26
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             img_valid,
    output logic             img_ready,
    input  tsi_pkg::image_t  img,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [4:0]       reg_index,
    output logic [7:0]       reg_value,
    output logic             last_byte
);

    tsi_pkg::image_t  buf_reg;
    logic             active_reg, active_next;
    tsi_pkg::index_t  cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    tsi_pkg::index_t  index_reg;
    logic [7:0]       value_reg;
    logic             last_reg;
    logic             load_out;
    logic             is_last;
    logic             take;

    assign img_ready = !active_reg;
    assign take      = img_valid && !active_reg;
    assign load_out  = active_reg && (!out_valid_reg || !out_stall);
    assign is_last   = cnt_reg == tsi_pkg::index_t'(IMAGE_BYTES - 1);

    assign out_valid = out_valid_reg;
    assign reg_index = index_reg;
    assign reg_value = value_reg;
    assign last_byte = last_reg;

    always_comb
    begin
        active_next    = active_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        if (load_out)
        begin
            cnt_next       = cnt_reg + tsi_pkg::index_t'(1);
            out_valid_next = 1'b1;
            if (is_last)
                active_next = 1'b0;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            buf_reg <= img;
        if (load_out)
        begin
            index_reg <= cnt_reg;
            value_reg <= buf_reg[cnt_reg];
            last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/tone_state_to_sid_register_image_top.sv =====
`timescale 1ns / 1ps
// channel   handshake             payload
// in        in_valid / in_stall   speaker_*, tandy_enabled, voice_*
// out       out_valid / out_stall reg_index, reg_value, last_byte
// cfg       cfg_we                cfg_wdata (sid clock, Hz)
//
// Compute per request: for each sounding voice one multiply, one add/compare and 16
// restoring-division steps (skipped when the quotient saturates); a silent slot is
// passed over, plus a pop and a handoff. Emission of IMAGE_BYTES bytes runs one
// byte a cycle while out_stall is low, alongside the next request's compute.
// Reset is asynchronous; no clearing pass. A two-entry queue decouples intake
// from the divider; out_stall holds the output register and backs up the queue.
module tone_state_to_sid_register_image_top
#(
    parameter int PIT_CLOCK_HZ = 1193182,
    parameter int PSG_CLOCK_HZ = 3579545,
    parameter int IMAGE_BYTES  = 26
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        speaker_active,
    input  logic [16:0] speaker_reload,
    input  logic [7:0]  speaker_token,
    input  logic        tandy_enabled,
    input  logic [2:0]  voice_active_mask,
    input  logic [29:0] voice_periods,
    input  logic [11:0] voice_attenuations,
    input  logic [23:0] voice_tokens,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  reg_index,
    output logic [7:0]  reg_value,
    output logic        last_byte
);

    tsi_pkg::clock_t  sid_clock_reg;
    tsi_pkg::job_t    front_job;
    tsi_pkg::job_t    queue_job;
    tsi_pkg::image_t  img;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    logic             img_valid;
    logic             img_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sid_clock_reg <= tsi_pkg::SID_CLOCK_RESET;
        else if (cfg_we)
            sid_clock_reg <= cfg_wdata;
    end

    tsi_front u_front
    (
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .speaker_active     (speaker_active),
        .speaker_reload     (speaker_reload),
        .speaker_token      (speaker_token),
        .tandy_enabled      (tandy_enabled),
        .voice_active_mask  (voice_active_mask),
        .voice_periods      (voice_periods),
        .voice_attenuations (voice_attenuations),
        .voice_tokens       (voice_tokens),
        .sid_clock          (sid_clock_reg),
        .q_full             (q_full),
        .push               (push),
        .job                (front_job)
    );

    tsi_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (front_job),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .job_out (queue_job)
    );

    tsi_engine
    #(
        .PIT_CLOCK_HZ (PIT_CLOCK_HZ),
        .PSG_CLOCK_HZ (PSG_CLOCK_HZ)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sid_clock (sid_clock_reg),
        .q_valid   (q_valid),
        .job_in    (queue_job),
        .pop       (pop),
        .img_valid (img_valid),
        .img_ready (img_ready),
        .img       (img)
    );

    tsi_emit
    #(
        .IMAGE_BYTES (IMAGE_BYTES)
    )
    u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .img_valid (img_valid),
        .img_ready (img_ready),
        .img       (img),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .reg_index (reg_index),
        .reg_value (reg_value),
        .last_byte (last_byte)
    );

endmodule

// ===== rtl/tsi_checker.sv =====
`timescale 1ns / 1ps
module tsi_checker
#(
    parameter int IMAGE_BYTES = 26
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] reg_index,
    input logic [7:0] reg_value,
    input logic       last_byte
);

    localparam logic [4:0] LAST_INDEX = 5'(IMAGE_BYTES - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(reg_index)
            && $stable(reg_value) && $stable(last_byte))
        else $error("stalled output changed");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (last_byte || reg_index == LAST_INDEX) |->
            last_byte && reg_index == LAST_INDEX)
        else $error("last flag and final index disagree");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_byte |=>
            out_valid && reg_index == $past(reg_index) + 5'd1)
        else $error("image bytes not back to back in index order");

    a_image_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_byte |=> !out_valid || reg_index == 5'd0)
        else $error("next image does not start at index zero");

endmodule

bind tone_state_to_sid_register_image_top tsi_checker
#(
    .IMAGE_BYTES (IMAGE_BYTES)
)
u_tsi_checker
(
    .*
);

// ===== sim/tb_tone_state_to_sid_register_image_top.sv =====
`timescale 1ns / 1ps
module tb_tone_state_to_sid_register_image_top;

    localparam int IMAGE_BYTES = 26;
    localparam longint unsigned PIT_HZ = 1193182;
    localparam longint unsigned PSG_HZ = 3579545;
    localparam int PSG_PRESCALE = 32;
    localparam logic [7:0] SPEAKER_SR = 8'hF0;
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        spk_on;
        logic [16:0] reload;
        logic [7:0]  spk_tok;
        logic        psg_on;
        logic [2:0]  mask;
        logic [29:0] periods;
        logic [11:0] atts;
        logic [23:0] toks;
    } snapshot_t;

    typedef struct packed {
        logic [4:0] index;
        logic [7:0] value;
        logic       last;
    } reg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        speaker_active = 1'b0;
    logic [16:0] speaker_reload = '0;
    logic [7:0]  speaker_token = '0;
    logic        tandy_enabled = 1'b0;
    logic [2:0]  voice_active_mask = '0;
    logic [29:0] voice_periods = '0;
    logic [11:0] voice_attenuations = '0;
    logic [23:0] voice_tokens = '0;
    logic        cfg_we = 1'b0;
    logic [23:0] cfg_wdata = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  reg_index;
    logic [7:0]  reg_value;
    logic        last_byte;

    // image predictor state
    tsi_pkg::clock_t           sid_clock = tsi_pkg::SID_CLOCK_RESET;
    logic [7:0]                last_spk_tok = '0;
    logic                      spk_sounding = 1'b0;
    logic [7:0]                last_voice_tok [tsi_pkg::SLOTS] = '{default: '0};
    logic [tsi_pkg::SLOTS-1:0] voice_sounding = '0;

    reg_write_t image_queue [$];
    snapshot_t  prev_sent = '0;
    int         tx_idle_pct = 0;
    int         rx_hold_pct = 0;
    int         mismatches = 0;

    tone_state_to_sid_register_image_top DUT
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .speaker_active     (speaker_active),
        .speaker_reload     (speaker_reload),
        .speaker_token      (speaker_token),
        .tandy_enabled      (tandy_enabled),
        .voice_active_mask  (voice_active_mask),
        .voice_periods      (voice_periods),
        .voice_attenuations (voice_attenuations),
        .voice_tokens       (voice_tokens),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .reg_index          (reg_index),
        .reg_value          (reg_value),
        .last_byte          (last_byte)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("** tone_state_to_sid_register_image_top: FAILED **");
        $finish;
    end

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("mismatch: %s", what);
        end
    endfunction

    function automatic logic [15:0] rounded_quotient(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned q;
        if (den == 0)
        begin
            return 16'd0;
        end
        q = (num + den / 2) / den;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    task automatic predict_image(input snapshot_t s);
        logic [7:0]      img [tsi_pkg::IMG_MAX];
        logic [15:0]     f;
        logic [9:0]      period;
        logic [3:0]      att;
        logic [7:0]      tok;
        longint unsigned den;
        int              base;
        reg_write_t      w;
        for (int i = 0; i < tsi_pkg::IMG_MAX; i++)
        begin
            img[i] = 8'h00;
        end
        if (s.psg_on && sid_clock != 0)
        begin
            for (int v = 0; v < tsi_pkg::SLOTS; v++)
            begin
                period = s.periods[tsi_pkg::PERIOD_W*v +: tsi_pkg::PERIOD_W];
                att = s.atts[tsi_pkg::ATT_W*v +: tsi_pkg::ATT_W];
                tok = s.toks[tsi_pkg::TOKEN_W*v +: tsi_pkg::TOKEN_W];
                f = 16'd0;
                if (s.mask[v])
                begin
                    den = period;
                    den = den * PSG_PRESCALE * sid_clock;
                    f = rounded_quotient(PSG_HZ << tsi_pkg::FRAC_SHIFT, den);
                end
                if (f == 16'd0)
                begin
                    voice_sounding[v] = 1'b0;
                end
                else
                begin
                    if (!voice_sounding[v] || last_voice_tok[v] != tok)
                    begin
                        img[tsi_pkg::RETRIG_INDEX][v] = 1'b1;
                    end
                    base = tsi_pkg::VOICE_BASE + tsi_pkg::VOICE_STRIDE * v;
                    img[base + tsi_pkg::OFS_FREQ_LO] = f[7:0];
                    img[base + tsi_pkg::OFS_FREQ_HI] = f[15:8];
                    img[base + tsi_pkg::OFS_PW_HI] = tsi_pkg::PULSE_WIDTH_HI;
                    img[base + tsi_pkg::OFS_CTRL] = tsi_pkg::CTRL_PULSE_GATE;
                    img[base + tsi_pkg::OFS_SR] = {4'hF - att, 4'h0};
                    last_voice_tok[v] = tok;
                    voice_sounding[v] = 1'b1;
                end
            end
            spk_sounding = 1'b0;
            img[tsi_pkg::VOLUME_INDEX] = tsi_pkg::MASTER_VOLUME;
        end
        else
        begin
            voice_sounding = '0;
            f = 16'd0;
            if (s.spk_on)
            begin
                den = s.reload;
                den = den * sid_clock;
                f = rounded_quotient(PIT_HZ << tsi_pkg::FRAC_SHIFT, den);
            end
            if (f != 16'd0)
            begin
                img[tsi_pkg::RETRIG_INDEX] =
                    (!spk_sounding || s.spk_tok != last_spk_tok) ? 8'h01 : 8'h00;
                img[tsi_pkg::VOICE_BASE + tsi_pkg::OFS_FREQ_LO] = f[7:0];
                img[tsi_pkg::VOICE_BASE + tsi_pkg::OFS_FREQ_HI] = f[15:8];
                img[tsi_pkg::VOICE_BASE + tsi_pkg::OFS_PW_HI] = tsi_pkg::PULSE_WIDTH_HI;
                img[tsi_pkg::VOICE_BASE + tsi_pkg::OFS_CTRL] = tsi_pkg::CTRL_PULSE_GATE;
                img[tsi_pkg::VOICE_BASE + tsi_pkg::OFS_SR] = SPEAKER_SR;
                img[tsi_pkg::VOLUME_INDEX] = tsi_pkg::MASTER_VOLUME;
            end
            spk_sounding = (f != 16'd0);
        end
        last_spk_tok = s.spk_tok;
        for (int i = 0; i < IMAGE_BYTES; i++)
        begin
            w.index = tsi_pkg::INDEX_W'(i);
            w.value = img[i];
            w.last = (i == IMAGE_BYTES - 1);
            image_queue.push_back(w);
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        reg_write_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (image_queue.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected byte idx %0d val %02h last %0b",
                                            reg_index, reg_value, last_byte));
                end
                else
                begin
                    want = image_queue.pop_front();
                    if (reg_index !== want.index || reg_value !== want.value ||
                        last_byte !== want.last)
                    begin
                        flag_mismatch($sformatf(
                            "expected idx %0d val %02h last %0b, got idx %0d val %02h last %0b",
                            want.index, want.value, want.last,
                            reg_index, reg_value, last_byte));
                    end
                end
            end
            out_stall <= (rx_hold_pct != 0) && ($urandom_range(99) < rx_hold_pct);
        end
    end

    task automatic send_snapshot(input snapshot_t s);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        speaker_active <= s.spk_on;
        speaker_reload <= s.reload;
        speaker_token <= s.spk_tok;
        tandy_enabled <= s.psg_on;
        voice_active_mask <= s.mask;
        voice_periods <= s.periods;
        voice_attenuations <= s.atts;
        voice_tokens <= s.toks;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_image(s);
        prev_sent = s;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (image_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sid_clock(input tsi_pkg::clock_t hz);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= hz;
        @(posedge clk);
        cfg_we <= 1'b0;
        sid_clock = hz;
    endtask

    function automatic snapshot_t speaker_snap(input logic on, input logic [16:0] reload,
                                               input logic [7:0] tok);
        snapshot_t s;
        s = '0;
        s.spk_on = on;
        s.reload = reload;
        s.spk_tok = tok;
        s.periods = {3{10'd100}};
        s.toks = 24'h5A5A5A;
        return s;
    endfunction

    function automatic snapshot_t psg_snap(input logic [2:0] mask, input logic [29:0] periods,
                                           input logic [11:0] atts, input logic [23:0] toks);
        snapshot_t s;
        s.spk_on = 1'b1;
        s.reload = 17'd100;
        s.spk_tok = toks[7:0] ^ 8'hA5;
        s.psg_on = 1'b1;
        s.mask = mask;
        s.periods = periods;
        s.atts = atts;
        s.toks = toks;
        return s;
    endfunction

    function automatic tsi_pkg::clock_t pick_sid_clock();
        int r;
        r = $urandom_range(99);
        if (r < 5)
        begin
            return '0;
        end
        else if (r < 20)
        begin
            return tsi_pkg::clock_t'($urandom_range(1, 2000));
        end
        else if (r < 40)
        begin
            return tsi_pkg::clock_t'($urandom);
        end
        return tsi_pkg::clock_t'($urandom_range(700000, 1100000));
    endfunction

    // mostly repeated tokens so both retrigger and sustain paths get exercised
    function automatic snapshot_t random_snapshot(input snapshot_t last);
        snapshot_t s;
        int r;
        s.spk_on = ($urandom_range(99) < 80);
        r = $urandom_range(99);
        if (r < 8)
        begin
            s.reload = '0;
        end
        else if (r < 20)
        begin
            s.reload = 17'($urandom);
        end
        else if (r < 35)
        begin
            s.reload = 17'($urandom_range(1, 64));
        end
        else
        begin
            s.reload = 17'($urandom_range(1, 65536));
        end
        s.spk_tok = ($urandom_range(99) < 70) ? last.spk_tok : 8'($urandom);
        s.psg_on = ($urandom_range(99) < 55);
        s.mask = ($urandom_range(99) < 60) ? 3'b111 : 3'($urandom);
        for (int v = 0; v < tsi_pkg::SLOTS; v++)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                s.periods[tsi_pkg::PERIOD_W*v +: tsi_pkg::PERIOD_W] = '0;
            end
            else if (r < 15)
            begin
                s.periods[tsi_pkg::PERIOD_W*v +: tsi_pkg::PERIOD_W] = 10'h3FF;
            end
            else if (r < 25)
            begin
                s.periods[tsi_pkg::PERIOD_W*v +: tsi_pkg::PERIOD_W] =
                    10'($urandom_range(1, 8));
            end
            else
            begin
                s.periods[tsi_pkg::PERIOD_W*v +: tsi_pkg::PERIOD_W] = 10'($urandom);
            end
            s.toks[tsi_pkg::TOKEN_W*v +: tsi_pkg::TOKEN_W] = ($urandom_range(99) < 70) ?
                last.toks[tsi_pkg::TOKEN_W*v +: tsi_pkg::TOKEN_W] : 8'($urandom);
        end
        s.atts = 12'($urandom);
        return s;
    endfunction

    task automatic test_speaker_path();
        send_snapshot(speaker_snap(1'b0, 17'd1000, 8'h00));
        send_snapshot(speaker_snap(1'b1, 17'd1, 8'h00));
        send_snapshot(speaker_snap(1'b1, 17'd65536, 8'h00));
        send_snapshot(speaker_snap(1'b1, 17'd1193, 8'hFF));
        send_snapshot(speaker_snap(1'b1, 17'd0, 8'hFF));
        send_snapshot(speaker_snap(1'b1, 17'h1FFFF, 8'hFF));
    endtask

    task automatic test_psg_path();
        snapshot_t s;
        send_snapshot(psg_snap(3'b111, {3{10'd1}}, 12'h000, 24'h000000));
        send_snapshot(psg_snap(3'b111, {3{10'h3FF}}, 12'hFFF, 24'h000000));
        send_snapshot(psg_snap(3'b111, {10'd500, 10'd300, 10'd100}, 12'h5A3, 24'hFF0000));
        send_snapshot(psg_snap(3'b101, {10'd200, 10'd0, 10'd254}, 12'h3C1, 24'hFF0000));
        send_snapshot(psg_snap(3'b111, {10'd0, 10'd50, 10'd60}, 12'h777, 24'hFF0000));
        send_snapshot(psg_snap(3'b000, {3{10'd80}}, 12'h123, 24'hFF0000));
        // speaker after the PSG path always retriggers
        send_snapshot(speaker_snap(1'b1, 17'd2000, 8'hA5));
        s = psg_snap(3'b111, {3{10'd90}}, 12'h000, 24'h123456);
        s.psg_on = 1'b0;
        send_snapshot(s);
    endtask

    task automatic test_zero_clock();
        write_sid_clock('0);
        send_snapshot(psg_snap(3'b111, {3{10'd100}}, 12'h000, 24'h010203));
        send_snapshot(speaker_snap(1'b1, 17'd100, 8'h11));
        send_snapshot(speaker_snap(1'b1, 17'd1, 8'h11));
    endtask

    task automatic test_clock_extremes();
        write_sid_clock(tsi_pkg::clock_t'(1));
        send_snapshot(psg_snap(3'b111, {3{10'h3FF}}, 12'hF0F, 24'hABCDEF));
        send_snapshot(speaker_snap(1'b1, 17'd65536, 8'h22));
        write_sid_clock(24'hFFFFFF);
        send_snapshot(psg_snap(3'b111, {10'h3FF, 10'd1, 10'd512}, 12'h8E1, 24'hABCDEF));
        send_snapshot(speaker_snap(1'b1, 17'd65536, 8'h22));
        send_snapshot(speaker_snap(1'b1, 17'd1, 8'h22));
        write_sid_clock(tsi_pkg::SID_CLOCK_RESET);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_hold_pct = rx_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 20 == 0)
            begin
                write_sid_clock(pick_sid_clock());
            end
            send_snapshot(random_snapshot(prev_sent));
        end
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_speaker_path();
        test_psg_path();
        test_zero_clock();
        test_clock_extremes();
        test_random_traffic(24, 67, 60);
        test_random_traffic(67, 24, 60);
        test_random_traffic(0, 0, 60);
        drain();
        if (mismatches == 0)
        begin
            $display("** tone_state_to_sid_register_image_top: PASSED **");
        end
        else
        begin
            $display("** tone_state_to_sid_register_image_top: FAILED **");
        end
        $finish;
    end

endmodule
